// ===== rtl/core/rate_monotonic_tick_scheduler_assert.svh =====
// Assertion macros for the rate-monotonic tick scheduler.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_ASSERT_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define RMTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmts: same-cycle check failed");
// next-cycle implication
`define RMTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmts: next-cycle check failed");
`else
`define RMTS_ASSERT_IMPL(lbl, ante, cons)
`define RMTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/rmts_pkg.sv =====
// Shared types and constants for the rate-monotonic tick scheduler.
// No dependencies.
package rmts_pkg;

  localparam int TASKS_DEF     = 8;
  localparam int TIME_BITS_DEF = 16;
  localparam int MAX_TIME_BITS = 32;  // widest period a cell may hold
  localparam int MAX_ID_BITS   = 6;   // ids for up to 64 tasks
  localparam int CNT_BITS      = 7;   // per-tick count, up to 64
  localparam int FIELD_BITS    = 16;  // width of burst, period, instances ports
  localparam int MASK_BITS     = 8;

  typedef enum logic {
    OP_ADMIT = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // admit write broadcast to every cell
  typedef struct packed {
    logic                  we;
    logic [2:0]            id;
    logic [FIELD_BITS-1:0] burst;
    logic [FIELD_BITS-1:0] period;
    logic [FIELD_BITS-1:0] instances;
  } admit_t;

  // scan record handed from cell to cell
  typedef struct packed {
    logic                     found;
    logic [MAX_TIME_BITS-1:0] best_period;
    logic [MAX_ID_BITS-1:0]   best_id;
    logic                     started;
    logic                     resumed;
    logic                     finished;
    logic                     kill_last;
    logic [MASK_BITS-1:0]     miss_mask;
    logic [CNT_BITS-1:0]      miss_inc;
    logic [CNT_BITS-1:0]      rel_inc;
  } carry_t;

  // end-of-tick update broadcast to every cell
  typedef struct packed {
    logic                   valid;
    logic                   found;
    logic [MAX_ID_BITS-1:0] sel;
    logic                   pre;
    logic [MAX_ID_BITS-1:0] last;
  } apply_t;

endpackage

// ===== rtl/core/rate_monotonic_tick_scheduler.sv =====
// Rate-monotonic tick scheduler: top level with the tick controller.
// Depends on rmts_pkg, rmts_cell and rate_monotonic_tick_scheduler_assert.svh.
//
// Usage: an item is taken on a rising edge with start high and busy low.
// in_op = admit loads burst, period and instance count into slot in_task_id
// in that same edge and gives no result; a slot at or above TASKS is ignored.
// in_op = tick starts a scan beat down a chain of TASKS cells, one cell per
// cycle; each cell checks its deadline, releases a job and offers itself as
// the shortest-period ready task. When the beat leaves the last cell the
// winner runs one tick, counters update and the result is strobed on
// out_valid for one cycle.
// Timing: a tick result is strobed once the scan beat has left the last cell and
// the result registers load; busy falls as they load, so a new item can be taken
// in the strobe cycle, and no item is taken while busy. An admit is accepted on
// its edge. The receiver cannot stall; results are never held.
// Reset clears all task slots, counters and the last-runner record.
`include "rate_monotonic_tick_scheduler_assert.svh"
module rate_monotonic_tick_scheduler import rmts_pkg::*; #(
  parameter int TASKS     = TASKS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [2:0]  in_task_id,
  input  logic [15:0] in_burst,
  input  logic [15:0] in_period,
  input  logic [15:0] in_instances,
  output logic        out_valid,
  output logic [2:0]  out_running_task,
  output logic        out_cpu_idle,
  output logic        out_job_started,
  output logic        out_job_resumed,
  output logic        out_job_finished,
  output logic        out_preempted,
  output logic [2:0]  out_preempted_task,
  output logic [7:0]  out_miss_mask,
  output logic [31:0] out_miss_total,
  output logic [31:0] out_released_total
);

  localparam int IDW = $clog2(TASKS);

  logic             busy_r;
  logic             last_valid_r, last_valid_nxt;
  logic [IDW-1:0]   last_runner_r, last_runner_nxt;
  logic [31:0]      miss_cnt_r, rel_cnt_r;
  logic             out_valid_r;
  logic [2:0]       run_task_r, pre_task_r;
  logic             idle_r, started_r, resumed_r, finished_r, pre_r;
  logic [7:0]       mask_r;

  logic             tick_acc, admit_acc, done, lv, pre;
  logic [IDW-1:0]   sel;
  logic [32:0]      miss_sum, rel_sum;
  admit_t           admit;
  apply_t           apply;
  carry_t           res;
  logic [TASKS:0]   pulse_w;
  carry_t           carry_w [TASKS+1];

  assign tick_acc  = start && !busy_r && (in_op == OP_TICK);
  assign admit_acc = start && !busy_r && (in_op == OP_ADMIT);

  assign admit.we        = admit_acc;
  assign admit.id        = in_task_id;
  assign admit.burst     = in_burst;
  assign admit.period    = in_period;
  assign admit.instances = in_instances;

  // head of the chain
  assign pulse_w[0] = tick_acc;
  assign carry_w[0] = '0;

  // cell chain
  for (genvar k = 0; k < TASKS; k++) begin : g_cell
    rmts_cell #(
      .TIME_BITS (TIME_BITS),
      .IDX       (k)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .admit_i       (admit),
      .pulse_i       (pulse_w[k]),
      .carry_i       (carry_w[k]),
      .last_valid_i  (last_valid_r),
      .last_runner_i (MAX_ID_BITS'(last_runner_r)),
      .apply_i       (apply),
      .pulse_o       (pulse_w[k+1]),
      .carry_o       (carry_w[k+1])
    );
  end

  assign done = pulse_w[TASKS];
  assign res  = carry_w[TASKS];

  // run step once the scan beat leaves the chain
  always_comb begin
    lv  = last_valid_r && !res.kill_last;
    sel = IDW'(res.best_id);
    pre = res.found && lv && (last_runner_r != sel);
    apply.valid = done;
    apply.found = res.found;
    apply.sel   = res.best_id;
    apply.pre   = pre;
    apply.last  = MAX_ID_BITS'(last_runner_r);
    last_valid_nxt  = lv;
    last_runner_nxt = last_runner_r;
    if (res.found) begin
      last_valid_nxt = !res.finished;
      if (!res.finished) begin
        last_runner_nxt = sel;
      end
    end
    miss_sum = {1'b0, miss_cnt_r} + 33'(res.miss_inc);
    rel_sum  = {1'b0, rel_cnt_r} + 33'(res.rel_inc);
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      last_valid_r  <= 1'b0;
      last_runner_r <= '0;
      miss_cnt_r    <= '0;
      rel_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= done;
      if (tick_acc) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (admit_acc) begin
        if (last_valid_r &&
            ((IDW + 3)'(in_task_id) == (IDW + 3)'(last_runner_r))) begin
          last_valid_r <= 1'b0;
        end
      end else if (done) begin
        last_valid_r  <= last_valid_nxt;
        last_runner_r <= last_runner_nxt;
        miss_cnt_r    <= miss_sum[32] ? '1 : miss_sum[31:0];
        rel_cnt_r     <= rel_sum[32] ? '1 : rel_sum[31:0];
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (done) begin
      run_task_r <= res.found ? 3'(sel) : 3'd0;
      idle_r     <= !res.found;
      started_r  <= res.found && res.started;
      resumed_r  <= res.found && res.resumed;
      finished_r <= res.found && res.finished;
      pre_r      <= pre;
      pre_task_r <= pre ? 3'(last_runner_r) : 3'd0;
      mask_r     <= res.miss_mask;
    end
  end

  assign busy               = busy_r;
  assign out_valid          = out_valid_r;
  assign out_running_task   = run_task_r;
  assign out_cpu_idle       = idle_r;
  assign out_job_started    = started_r;
  assign out_job_resumed    = resumed_r;
  assign out_job_finished   = finished_r;
  assign out_preempted      = pre_r;
  assign out_preempted_task = pre_task_r;
  assign out_miss_mask      = mask_r;
  assign out_miss_total     = miss_cnt_r;
  assign out_released_total = rel_cnt_r;

  // only one cell holds the scan beat at a time
  `RMTS_ASSERT_IMPL(a_one_beat, 1'b1, $onehot0(pulse_w[TASKS:1]))
  // a tick accept keeps the block busy for the scan
  `RMTS_ASSERT_NEXT(a_tick_busy, tick_acc, busy_r)
  // a result ends the scan
  `RMTS_ASSERT_IMPL(a_res_free, out_valid_r, !busy_r)
  // an idle tick reports no job activity
  `RMTS_ASSERT_IMPL(a_idle_quiet, out_valid_r && idle_r,
                    !started_r && !finished_r && !pre_r && !resumed_r)

endmodule

// ===== rtl/core/rmts_cell.sv =====
// One task slot of the scheduler chain: holds the task state, does the
// boundary check and release when the scan beat arrives. Uses rmts_pkg.
module rmts_cell import rmts_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int IDX       = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  admit_t admit_i,
  input  logic   pulse_i,
  input  carry_t carry_i,
  input  logic   last_valid_i,
  input  logic [MAX_ID_BITS-1:0] last_runner_i,
  input  apply_t apply_i,
  output logic   pulse_o,
  output carry_t carry_o
);

  localparam logic [MAX_ID_BITS-1:0] MY_ID = MAX_ID_BITS'(IDX);

  logic [TIME_BITS-1:0]  burst_r, period_r, work_r, cd_r;
  logic [FIELD_BITS-1:0] jobs_r;
  logic                  wp_r;
  logic                  pulse_r;
  carry_t                carry_r;

  logic                  hit, boundary, miss, rel, ready, take;
  logic [TIME_BITS-1:0]  work_nxt, cd_nxt;
  logic [FIELD_BITS-1:0] jobs_nxt;
  logic                  wp_nxt;
  carry_t                carry_nxt;

  assign hit = admit_i.we && (MAX_ID_BITS'(admit_i.id) == MY_ID);

  // boundary check, release and priority compare
  always_comb begin
    boundary = (cd_r == '0);
    miss     = boundary && (work_r != '0);
    rel      = boundary && (jobs_r != '0);
    work_nxt = rel ? burst_r : (miss ? '0 : work_r);
    wp_nxt   = (miss || rel) ? 1'b0 : wp_r;
    jobs_nxt = rel ? jobs_r - 1'b1 : jobs_r;
    cd_nxt   = rel ? ((period_r != '0) ? period_r : TIME_BITS'(1)) : cd_r;
    ready    = (work_nxt != '0);
    take     = ready && (!carry_i.found ||
               (MAX_TIME_BITS'(period_r) < carry_i.best_period));

    carry_nxt = carry_i;
    if (take) begin
      carry_nxt.found       = 1'b1;
      carry_nxt.best_period = MAX_TIME_BITS'(period_r);
      carry_nxt.best_id     = MY_ID;
      carry_nxt.started     = (work_nxt == burst_r);
      carry_nxt.resumed     = wp_nxt;
      carry_nxt.finished    = (work_nxt == TIME_BITS'(1));
    end
    if (miss) begin
      carry_nxt.miss_inc  = carry_i.miss_inc + 1'b1;
      carry_nxt.miss_mask = carry_i.miss_mask |
                            ((IDX < MASK_BITS) ? (MASK_BITS'(1) << IDX) : '0);
      if (last_valid_i && (last_runner_i == MY_ID)) begin
        carry_nxt.kill_last = 1'b1;
      end
    end
    if (rel) begin
      carry_nxt.rel_inc = carry_i.rel_inc + 1'b1;
    end
  end

  // task state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r  <= '0;
      period_r <= '0;
      jobs_r   <= '0;
      work_r   <= '0;
      cd_r     <= '0;
      wp_r     <= 1'b0;
      pulse_r  <= 1'b0;
    end else begin
      pulse_r <= pulse_i;
      if (hit) begin
        burst_r  <= TIME_BITS'(admit_i.burst);
        period_r <= TIME_BITS'(admit_i.period);
        jobs_r   <= admit_i.instances;
        work_r   <= '0;
        cd_r     <= '0;
        wp_r     <= 1'b0;
      end else if (pulse_i) begin
        work_r <= work_nxt;
        wp_r   <= wp_nxt;
        cd_r   <= cd_nxt;
        jobs_r <= jobs_nxt;
      end else if (apply_i.valid) begin
        if (cd_r != '0) begin
          cd_r <= cd_r - 1'b1;
        end
        if (apply_i.found && (apply_i.sel == MY_ID)) begin
          work_r <= work_r - 1'b1;
          wp_r   <= 1'b0;
        end
        if (apply_i.pre && (apply_i.last == MY_ID)) begin
          wp_r <= 1'b1;
        end
      end
    end
  end

  // scan record toward the next cell
  always_ff @(posedge clk) begin
    if (pulse_i) begin
      carry_r <= carry_nxt;
    end
  end

  assign pulse_o = pulse_r;
  assign carry_o = carry_r;

endmodule

// ===== tb/sv/rate_monotonic_tick_scheduler_checker.sv =====
// Checker for the rate-monotonic tick scheduler: mirrors the task table, predicts each tick
// result, compares it with the strobed one and counts failures.
// Depends on rmts_pkg.
`timescale 1ns / 1ps
module rate_monotonic_tick_scheduler_checker import rmts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_op,
  input  logic [2:0]  in_task_id,
  input  logic [15:0] in_burst,
  input  logic [15:0] in_period,
  input  logic [15:0] in_instances,
  input  logic        out_valid,
  input  logic [2:0]  out_running_task,
  input  logic        out_cpu_idle,
  input  logic        out_job_started,
  input  logic        out_job_resumed,
  input  logic        out_job_finished,
  input  logic        out_preempted,
  input  logic [2:0]  out_preempted_task,
  input  logic [7:0]  out_miss_mask,
  input  logic [31:0] out_miss_total,
  input  logic [31:0] out_released_total,
  output int          fail_count,
  output int          outstanding
);

  localparam int SLOTS       = TASKS_DEF;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [2:0]  runner;
    logic        idle;
    logic        started;
    logic        resumed;
    logic        finished;
    logic        preempted;
    logic [2:0]  victim;
    logic [7:0]  missed;
    logic [31:0] miss_sum;
    logic [31:0] rel_sum;
  } tick_result_t;

  // mirrored task table
  logic [15:0] burst_q     [SLOTS];
  logic [15:0] period_q    [SLOTS];
  logic [15:0] jobs_q      [SLOTS];
  logic [15:0] work_q      [SLOTS];
  logic [15:0] countdown_q [SLOTS];
  logic        preempt_mark[SLOTS];
  logic        last_ok;
  logic [2:0]  last_id;
  logic [31:0] misses;
  logic [31:0] releases;

  tick_result_t expected_ticks[$];
  int           results_seen;

  function automatic logic [31:0] sat_up(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    // quiet after the first few dozen, but keep counting
    if (fail_count < PRINT_LIMIT)
      $display("[%0t] tick result %0d: %s got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
    fail_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // one scheduler tick: deadline checks, releases, rate-monotonic pick, counters
  task automatic schedule_tick(output tick_result_t r);
    logic [7:0] mask;
    logic       found;
    logic [2:0] sel;
    r     = '0;
    mask  = '0;
    found = 1'b0;
    sel   = '0;
    // boundary: drop unfinished job as a miss, then release the next one
    for (int i = 0; i < SLOTS; i++) begin
      if (countdown_q[i] == 16'd0) begin
        if (work_q[i] != 16'd0) begin
          work_q[i]       = '0;
          preempt_mark[i] = 1'b0;
          misses          = sat_up(misses);
          mask[i]         = 1'b1;
          if (last_ok && last_id == i) last_ok = 1'b0;
        end
        if (jobs_q[i] != 16'd0) begin
          jobs_q[i]       = jobs_q[i] - 16'd1;
          work_q[i]       = burst_q[i];
          preempt_mark[i] = 1'b0;
          countdown_q[i]  = (period_q[i] != 16'd0) ? period_q[i] : 16'd1;
          releases        = sat_up(releases);
        end
      end
    end
    // shortest period wins, lowest id on ties
    for (int i = 0; i < SLOTS; i++) begin
      if (work_q[i] != 16'd0 && (!found || period_q[i] < period_q[sel])) begin
        found = 1'b1;
        sel   = 3'(i);
      end
    end
    if (found) begin
      if (last_ok && last_id != sel) begin
        r.preempted           = 1'b1;
        r.victim              = last_id;
        preempt_mark[last_id] = 1'b1;
      end
      r.started = (work_q[sel] == burst_q[sel]);
      if (preempt_mark[sel]) begin
        r.resumed         = 1'b1;
        preempt_mark[sel] = 1'b0;
      end
      work_q[sel] = work_q[sel] - 16'd1;
      if (work_q[sel] == 16'd0) begin
        r.finished = 1'b1;
        last_ok    = 1'b0;
      end else begin
        last_ok = 1'b1;
        last_id = sel;
      end
    end
    for (int i = 0; i < SLOTS; i++)
      if (countdown_q[i] != 16'd0) countdown_q[i] = countdown_q[i] - 16'd1;
    r.runner   = found ? sel : 3'd0;
    r.idle     = !found;
    r.missed   = mask;
    r.miss_sum = misses;
    r.rel_sum  = releases;
  endtask

  // results first, so a beat taken in the strobe cycle queues behind it
  always @(posedge clk) begin : watch
    tick_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        burst_q[i]      = '0;
        period_q[i]     = '0;
        jobs_q[i]       = '0;
        work_q[i]       = '0;
        countdown_q[i]  = '0;
        preempt_mark[i] = 1'b0;
      end
      last_ok      = 1'b0;
      last_id      = '0;
      misses       = '0;
      releases     = '0;
      results_seen = 0;
      fail_count   = 0;
      expected_ticks.delete();
    end else begin
      if (out_valid) begin
        results_seen++;
        if (expected_ticks.size() == 0) begin
          report_mismatch("result with no tick pending", 32'd0, 32'd0);
        end else begin
          want = expected_ticks.pop_front();
          check_field("running_task", 32'(out_running_task), 32'(want.runner));
          check_field("cpu_idle", 32'(out_cpu_idle), 32'(want.idle));
          check_field("job_started", 32'(out_job_started), 32'(want.started));
          check_field("job_resumed", 32'(out_job_resumed), 32'(want.resumed));
          check_field("job_finished", 32'(out_job_finished), 32'(want.finished));
          check_field("preempted", 32'(out_preempted), 32'(want.preempted));
          check_field("preempted_task", 32'(out_preempted_task), 32'(want.victim));
          check_field("miss_mask", 32'(out_miss_mask), 32'(want.missed));
          check_field("miss_total", out_miss_total, want.miss_sum);
          check_field("released_total", out_released_total, want.rel_sum);
        end
      end
      if (start && !busy) begin
        if (in_op == OP_TICK) begin
          schedule_tick(want);
          expected_ticks.push_back(want);
        end else begin
          // admit: reload the slot and drop its pending job
          burst_q[in_task_id]      = in_burst;
          period_q[in_task_id]     = in_period;
          jobs_q[in_task_id]       = in_instances;
          work_q[in_task_id]       = '0;
          countdown_q[in_task_id]  = '0;
          preempt_mark[in_task_id] = 1'b0;
          if (last_ok && last_id == in_task_id) last_ok = 1'b0;
        end
      end
    end
    outstanding = expected_ticks.size();
  end

endmodule

// ===== tb/sv/rate_monotonic_tick_scheduler_tb.sv =====
// Testbench top for the rate-monotonic tick scheduler: clock, reset, directed and random
// admit/tick beats with bursty gaps, watchdog and verdict.
// Depends on rmts_pkg, rate_monotonic_tick_scheduler and rate_monotonic_tick_scheduler_checker.
`timescale 1ns / 1ps
module rate_monotonic_tick_scheduler_tb;
  import rmts_pkg::*;

  localparam int RANDOM_BEATS = 1925;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = TASKS_DEF + 4;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_op;
  logic [2:0]  in_task_id;
  logic [15:0] in_burst;
  logic [15:0] in_period;
  logic [15:0] in_instances;
  logic        out_valid;
  logic [2:0]  out_running_task;
  logic        out_cpu_idle;
  logic        out_job_started;
  logic        out_job_resumed;
  logic        out_job_finished;
  logic        out_preempted;
  logic [2:0]  out_preempted_task;
  logic [7:0]  out_miss_mask;
  logic [31:0] out_miss_total;
  logic [31:0] out_released_total;

  int fail_count;
  int outstanding;
  int idle_run;
  int beats_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  rate_monotonic_tick_scheduler i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_task_id         (in_task_id),
    .in_burst           (in_burst),
    .in_period          (in_period),
    .in_instances       (in_instances),
    .out_valid          (out_valid),
    .out_running_task   (out_running_task),
    .out_cpu_idle       (out_cpu_idle),
    .out_job_started    (out_job_started),
    .out_job_resumed    (out_job_resumed),
    .out_job_finished   (out_job_finished),
    .out_preempted      (out_preempted),
    .out_preempted_task (out_preempted_task),
    .out_miss_mask      (out_miss_mask),
    .out_miss_total     (out_miss_total),
    .out_released_total (out_released_total)
  );

  rate_monotonic_tick_scheduler_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_task_id         (in_task_id),
    .in_burst           (in_burst),
    .in_period          (in_period),
    .in_instances       (in_instances),
    .out_valid          (out_valid),
    .out_running_task   (out_running_task),
    .out_cpu_idle       (out_cpu_idle),
    .out_job_started    (out_job_started),
    .out_job_resumed    (out_job_resumed),
    .out_job_finished   (out_job_finished),
    .out_preempted      (out_preempted),
    .out_preempted_task (out_preempted_task),
    .out_miss_mask      (out_miss_mask),
    .out_miss_total     (out_miss_total),
    .out_released_total (out_released_total),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  // watchdog: too many cycles with no beat taken and no result strobed
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("** rate_monotonic_tick_scheduler: FAILED **");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // one beat, with a random gap ahead of it when the current burst is used up
  task automatic send_beat(input logic op, input logic [2:0] id, input logic [15:0] b,
                           input logic [15:0] p, input logic [15:0] n);
    int gap;
    if (beats_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      beats_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    beats_left--;
    start        <= 1'b1;
    in_op        <= op;
    in_task_id   <= id;
    in_burst     <= b;
    in_period    <= p;
    in_instances <= n;
    do @(posedge clk); while (busy);
  endtask

  // tick beat; the unused fields carry junk
  task automatic advance_tick();
    send_beat(OP_TICK, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
  endtask

  // hold off until every pending tick result has come back
  task automatic wait_all_results();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // mostly small values so periods wrap and jobs collide; now and then any 16-bit value
  function automatic logic [15:0] pick_field(input int hi);
    return 16'(($urandom_range(0, 11) == 0) ? $urandom_range(0, 65535) :
               $urandom_range(0, hi));
  endfunction

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_op        <= OP_ADMIT;
    in_task_id   <= '0;
    in_burst     <= '0;
    in_period    <= '0;
    in_instances <= '0;
    beats_left   = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: idle tick
    advance_tick();
    // two equal-period tasks, then a lower id with the same period displaces on a tie
    send_beat(OP_ADMIT, 3'd3, 16'd3, 16'd5, 16'd2);
    send_beat(OP_ADMIT, 3'd5, 16'd2, 16'd5, 16'd3);
    repeat (2) advance_tick();
    send_beat(OP_ADMIT, 3'd1, 16'd2, 16'd5, 16'd1);
    repeat (3) advance_tick();
    // field extremes, zero burst, zero period
    send_beat(OP_ADMIT, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(OP_ADMIT, 3'd6, 16'd0, 16'd3, 16'd2);
    send_beat(OP_ADMIT, 3'd2, 16'd1, 16'd0, 16'd3);
    repeat (4) advance_tick();
    // re-admit: retire task 2, reload running task 7 so its job overruns the last instance
    send_beat(OP_ADMIT, 3'd2, 16'd1, 16'd1, 16'd0);
    send_beat(OP_ADMIT, 3'd7, 16'd4, 16'd2, 16'd1);
    repeat (5) advance_tick();

    // random mix, mostly ticks, with a full drain now and then
    for (int k = 0; k < RANDOM_BEATS; k++) begin
      if (k % 500 == 250) wait_all_results();
      if ($urandom_range(0, 5) == 0)
        send_beat(OP_ADMIT, 3'($urandom_range(0, 7)), pick_field(6), pick_field(20),
                  pick_field(30));
      else
        advance_tick();
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("** rate_monotonic_tick_scheduler: PASSED **");
    else
      $display("** rate_monotonic_tick_scheduler: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rmts_pkg.sv
rtl/core/rmts_cell.sv
rtl/core/rate_monotonic_tick_scheduler.sv
tb/sv/rate_monotonic_tick_scheduler_checker.sv
tb/sv/rate_monotonic_tick_scheduler_tb.sv
